### src/vhdd_pkg.sv
// Shared constants and register codes for the hard-decision Viterbi decoder.
package vhdd_pkg;

   localparam int GEN_W       = 11;  // generator polynomial register width
   localparam int NUM_GEN     = 6;   // generator registers on the CSR map
   localparam int KCFG_W      = 4;   // constraint length register width
   localparam int NCFG_W      = 3;   // output count register width
   localparam int RX_W        = 6;   // received symbol width
   localparam int BM_W        = 3;   // branch metric width (0..6)
   localparam int STATE_OUT_W = 11;  // reported best state width
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 11;

   localparam int K_RESET   = 7;
   localparam int N_RESET   = 2;
   localparam int GEN_RESET = 35;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_CONSTRAINT = 3'd0,
      CSR_NUM_OUT    = 3'd1,
      CSR_GEN0       = 3'd2,
      CSR_GEN1       = 3'd3,
      CSR_GEN2       = 3'd4,
      CSR_GEN3       = 3'd5,
      CSR_GEN4       = 3'd6,
      CSR_GEN5       = 3'd7
   } csr_index_type;

endpackage

### src/viterbi_hard_decision_decoder_core.sv
// Hard-decision Viterbi add-compare-select core with a shared ACS unit.
//
// Usage:
//   req_* carries one received symbol per request: received_bits (bit i is
//   the hard decision for generator i) and first (restart the trellis at
//   state 0 before this symbol). rsp_* returns one result per request: the
//   lowest-index state holding the minimum path metric and its LSB.
//   csr_* writes the constraint length, output count and generators; write
//   only while the core is idle.
// Timing:
//   A request runs one ACS pass per trellis state through a single shared
//   ACS unit fed by a dual-read metric memory, one state per cycle, behind a
//   three-deep pipeline (read, add, select/write). req_stall is high from
//   acceptance until the result is handed to the output register.
//   Metrics ping-pong between two banks of one memory; normalization is
//   folded into the next pass by subtracting the previous minimum on read.
// Reset: synchronous, active high. Registers return to K = 7, two outputs,
//   generators 35; the trellis starts with only state 0 reachable.
//   No clearing pass is needed, a restart flag stands in for the memory.
// Stall: a finished result is held in the output register; if it is still
//   stalled when the next result is ready, the core waits before taking
//   another request.
module viterbi_hard_decision_decoder_core #(
   parameter int MAX_CONSTRAINT = 12,
   parameter int MAX_OUTPUTS    = 6,
   parameter int METRIC_WIDTH   = 12
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [vhdd_pkg::RX_W-1:0]           req_received_bits,
   input  logic                                req_first,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_decoded_bit,
   output logic [vhdd_pkg::STATE_OUT_W-1:0]    rsp_best_state,
   // configuration
   input  logic                                csr_we,
   input  logic [vhdd_pkg::CSR_ADDR_W-1:0]     csr_index,
   input  logic [vhdd_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import vhdd_pkg::*;

   localparam int SW    = MAX_CONSTRAINT - 1;              // state index width
   localparam int MW    = METRIC_WIDTH;
   localparam int EW    = MW + 1;                          // reach bit + metric
   localparam int DEPTH = 2 ** MAX_CONSTRAINT;             // two banks
   localparam int TW    = (MAX_CONSTRAINT > GEN_W + 1) ? MAX_CONSTRAINT : GEN_W + 1;
   localparam int BW    = (SW > STATE_OUT_W) ? SW : STATE_OUT_W;
   localparam int NMAX  = (MAX_OUTPUTS < NUM_GEN) ? MAX_OUTPUTS : NUM_GEN;

   typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} state_type;

   // ---------------- configuration registers ----------------
   logic [KCFG_W-1:0] k_cfg_ff;
   logic [NCFG_W-1:0] n_cfg_ff;
   logic [GEN_W-1:0]  gen_ff [NUM_GEN];

   always_ff @(posedge clock) begin
      if (reset) begin
         k_cfg_ff <= KCFG_W'(K_RESET);
         n_cfg_ff <= NCFG_W'(N_RESET);
         for (int i = 0; i < NUM_GEN; i++) gen_ff[i] <= GEN_W'(GEN_RESET);
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_CONSTRAINT: k_cfg_ff  <= csr_wdata[KCFG_W-1:0];
            CSR_NUM_OUT:    n_cfg_ff  <= csr_wdata[NCFG_W-1:0];
            CSR_GEN0:       gen_ff[0] <= csr_wdata;
            CSR_GEN1:       gen_ff[1] <= csr_wdata;
            CSR_GEN2:       gen_ff[2] <= csr_wdata;
            CSR_GEN3:       gen_ff[3] <= csr_wdata;
            CSR_GEN4:       gen_ff[4] <= csr_wdata;
            CSR_GEN5:       gen_ff[5] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------- derived trellis geometry ----------------
   logic [4:0]              kc;
   logic [NCFG_W-1:0]       nc;
   logic [SW:0]             ns;
   logic [SW-1:0]           top;
   logic [MAX_CONSTRAINT:0] kfull;
   logic [MAX_CONSTRAINT-1:0] kmask;
   logic [RX_W:0]           nfull;
   logic [RX_W-1:0]         nmask;
   logic [MAX_CONSTRAINT-1:0] taps [NUM_GEN];
   logic [TW-1:0]           taps_t [NUM_GEN];

   always_comb begin
      if (k_cfg_ff < KCFG_W'(2))                     kc = 5'd2;
      else if (int'(k_cfg_ff) > MAX_CONSTRAINT)      kc = 5'(MAX_CONSTRAINT);
      else                                           kc = {1'b0, k_cfg_ff};
      if (n_cfg_ff == '0)                            nc = NCFG_W'(1);
      else if (int'(n_cfg_ff) > NMAX)                nc = NCFG_W'(NMAX);
      else                                           nc = n_cfg_ff;
      ns    = (SW+1)'(1) << (kc - 5'd1);
      top   = SW'(1) << (kc - 5'd2);
      kfull = ((MAX_CONSTRAINT+1)'(1) << kc) - (MAX_CONSTRAINT+1)'(1);
      kmask = kfull[MAX_CONSTRAINT-1:0];
      nfull = ((RX_W+1)'(1) << nc) - (RX_W+1)'(1);
      nmask = nfull[RX_W-1:0];
      for (int i = 0; i < NUM_GEN; i++) begin
         taps_t[i] = TW'({gen_ff[i], 1'b1});
         taps[i]   = taps_t[i][MAX_CONSTRAINT-1:0] & kmask;
      end
   end

   function automatic logic [BM_W-1:0] popc(input logic [RX_W-1:0] v);
      logic [BM_W-1:0] c;
      c = '0;
      for (int i = 0; i < RX_W; i++) c = c + BM_W'(v[i]);
      return c;
   endfunction

   // ---------------- control state ----------------
   state_type         state_ff;
   logic [SW:0]       iss_ff;       // next state index to issue
   logic              bank_ff;      // bank holding the previous metrics
   logic              fresh_ff;     // previous metrics are the restart state
   logic [SW:0]       vns_ff;       // states valid in the previous bank
   logic [MW-1:0]     offset_ff;    // minimum of the previous bank
   logic [RX_W-1:0]   rx_ff;
   logic              any_ff;
   logic [MW-1:0]     min_ff;
   logic [SW-1:0]     best_ff;
   logic              rsp_valid_ff;
   logic              rsp_bit_ff;
   logic [STATE_OUT_W-1:0] rsp_state_ff;

   logic req_take;
   logic run_issue;
   logic pass_end;
   logic out_free;

   // pipeline flags
   logic v1_ff, v2_ff;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign run_issue = (state_ff == ST_RUN) && (iss_ff < ns);
   assign pass_end  = (state_ff == ST_RUN) && (iss_ff == ns) && !v1_ff && !v2_ff;
   assign out_free  = !(rsp_valid_ff && rsp_stall);

   // ---------------- stage 0: addresses and branch metrics ----------------
   logic [SW-1:0] s0, p0, p1;
   logic [SW-1:0] pc [2];
   logic [MAX_CONSTRAINT-1:0] enc;
   logic [RX_W-1:0] expect_bits;
   logic [BM_W-1:0] bm0 [2];
   logic            use_mem0 [2];
   logic            freach0 [2];

   always_comb begin
      s0    = iss_ff[SW-1:0];
      p0    = s0 >> 1;
      p1    = p0 | top;
      pc[0] = p0;
      pc[1] = p1;
      enc   = '0;
      expect_bits = '0;
      for (int c = 0; c < 2; c++) begin
         enc = {pc[c], s0[0]} & kmask;
         expect_bits = '0;
         for (int i = 0; i < NUM_GEN; i++) expect_bits[i] = ^(taps[i] & enc);
         bm0[c]      = popc((expect_bits ^ rx_ff) & nmask);
         use_mem0[c] = !fresh_ff && ({1'b0, pc[c]} < vns_ff);
         freach0[c]  = fresh_ff && (pc[c] == '0);
      end
   end

   // ---------------- metric memory ----------------
   logic [EW-1:0] mem [DEPTH];
   logic [EW-1:0] rd_ff [2];
   logic          wr_en;
   logic [SW-1:0] wr_addr;
   logic [EW-1:0] wr_data;

   always_ff @(posedge clock) begin
      if (run_issue) begin
         rd_ff[0] <= mem[{bank_ff, p0}];
         rd_ff[1] <= mem[{bank_ff, p1}];
      end
      if (wr_en) mem[{~bank_ff, wr_addr}] <= wr_data;
   end

   // ---------------- stage 1: add with saturation ----------------
   logic [SW-1:0]   s1_ff;
   logic [BM_W-1:0] bm1_ff [2];
   logic            use_mem1_ff [2];
   logic            freach1_ff [2];

   always_ff @(posedge clock) begin
      if (run_issue) begin
         s1_ff <= s0;
         for (int c = 0; c < 2; c++) begin
            bm1_ff[c]      <= bm0[c];
            use_mem1_ff[c] <= use_mem0[c];
            freach1_ff[c]  <= freach0[c];
         end
      end
   end

   logic [MW-1:0] old_m [2];
   logic          old_r [2];
   logic [MW:0]   sum [2];
   logic [MW-1:0] cand [2];

   always_comb begin
      for (int c = 0; c < 2; c++) begin
         old_m[c] = use_mem1_ff[c] ? (rd_ff[c][MW-1:0] - offset_ff) : '0;
         old_r[c] = use_mem1_ff[c] ? rd_ff[c][MW] : freach1_ff[c];
         sum[c]   = {1'b0, old_m[c]} + (MW+1)'(bm1_ff[c]);
         cand[c]  = sum[c][MW] ? {MW{1'b1}} : sum[c][MW-1:0];
      end
   end

   // ---------------- stage 2: compare, select, write, running minimum ----------------
   logic [SW-1:0] s2_ff;
   logic [MW-1:0] c2_ff [2];
   logic          r2_ff [2];

   always_ff @(posedge clock) begin
      if (v1_ff) begin
         s2_ff <= s1_ff;
         for (int c = 0; c < 2; c++) begin
            c2_ff[c] <= cand[c];
            r2_ff[c] <= old_r[c];
         end
      end
   end

   logic          new_r;
   logic [MW-1:0] new_m;
   logic          take_min;

   always_comb begin
      // on a tie the predecessor s>>1 keeps the state
      priority if (r2_ff[0] && (!r2_ff[1] || c2_ff[0] <= c2_ff[1])) begin
         new_m = c2_ff[0];
      end else if (r2_ff[1]) begin
         new_m = c2_ff[1];
      end else begin
         new_m = '0;
      end
      new_r    = r2_ff[0] || r2_ff[1];
      wr_en    = v2_ff;
      wr_addr  = s2_ff;
      wr_data  = {new_r, new_m};
      take_min = v2_ff && new_r && (!any_ff || new_m < min_ff);
   end

   always_ff @(posedge clock) begin
      if (take_min) begin
         min_ff  <= new_m;
         best_ff <= s2_ff;
      end
   end

   // ---------------- sequencer ----------------
   logic [BW-1:0] best_wide;
   assign best_wide = BW'(best_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         iss_ff       <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         bank_ff      <= 1'b0;
         fresh_ff     <= 1'b1;
         vns_ff       <= '0;
         any_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // in ST_DONE the case arm below decides the output valid
         if (rsp_valid_ff && !rsp_stall && state_ff != ST_DONE) rsp_valid_ff <= 1'b0;
         v1_ff <= run_issue;
         v2_ff <= v1_ff;
         if (take_min) any_ff <= 1'b1;
         unique case (state_ff)
            ST_IDLE: begin
               if (req_take) begin
                  rx_ff    <= req_received_bits;
                  fresh_ff <= fresh_ff | req_first;
                  iss_ff   <= '0;
                  any_ff   <= 1'b0;
                  state_ff <= ST_RUN;
               end
            end
            ST_RUN: begin
               if (run_issue) iss_ff <= iss_ff + (SW+1)'(1);
               if (pass_end) begin
                  bank_ff   <= ~bank_ff;
                  fresh_ff  <= 1'b0;
                  vns_ff    <= ns;
                  offset_ff <= any_ff ? min_ff : '0;
                  state_ff  <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_bit_ff   <= any_ff ? best_ff[0] : 1'b0;
                  rsp_state_ff <= any_ff ? best_wide[STATE_OUT_W-1:0] : '0;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_decoded_bit = rsp_bit_ff;
   assign rsp_best_state  = rsp_state_ff;

endmodule

### tb/vhdd_decision_checker.sv
// Checker for the hard-decision Viterbi core: mirrors the trellis and compares decisions.
module vhdd_decision_checker #(
   parameter int MAX_CONSTRAINT = 12,
   parameter int MAX_OUTPUTS    = 6,
   parameter int METRIC_WIDTH   = 12
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_stall,
   input  logic [vhdd_pkg::RX_W-1:0]          req_received_bits,
   input  logic                               req_first,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  logic                               rsp_decoded_bit,
   input  logic [vhdd_pkg::STATE_OUT_W-1:0]   rsp_best_state,
   input  logic                               csr_we,
   input  logic [vhdd_pkg::CSR_ADDR_W-1:0]    csr_index,
   input  logic [vhdd_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output int                                 mismatches,
   output int                                 outstanding
);
   import vhdd_pkg::*;

   localparam int     SLOTS      = 1 << (MAX_CONSTRAINT - 1);
   localparam int     N_LIMIT    = (MAX_OUTPUTS < NUM_GEN) ? MAX_OUTPUTS : NUM_GEN;
   localparam longint METRIC_TOP = longint'((64'd1 << METRIC_WIDTH) - 64'd1);

   typedef struct packed {
      logic                   decoded_bit;
      logic [STATE_OUT_W-1:0] best_state;
   } decision_type;

   decision_type expected_decisions[$];

   logic [KCFG_W-1:0] k_reg;
   logic [NCFG_W-1:0] n_reg;
   logic [GEN_W-1:0]  gen_reg [NUM_GEN];

   longint metric      [SLOTS];
   bit     reachable   [SLOTS];
   longint metric_nx   [SLOTS];
   bit     reachable_nx[SLOTS];

   task automatic report_mismatch(string msg);
      $display("%0t: mismatch: %s", $time, msg);
      mismatches++;
   endtask

   function automatic void clear_trellis();
      foreach (metric[i]) begin
         metric[i]    = 0;
         reachable[i] = 1'b0;
      end
      reachable[0] = 1'b1;
   endfunction

   // one symbol of add-compare-select, then normalization and the decision
   function automatic decision_type acs_decide(logic [RX_W-1:0] rx_bits, logic restart);
      int           k, n, ns, top, kmask, rx, p, regv, taps, exp_bits, best;
      longint       cand, minm;
      bit           any;
      decision_type d;
      k = int'(k_reg);
      if (k < 2) k = 2;
      if (k > MAX_CONSTRAINT) k = MAX_CONSTRAINT;
      n = int'(n_reg);
      if (n < 1) n = 1;
      if (n > N_LIMIT) n = N_LIMIT;
      ns    = 1 << (k - 1);
      top   = 1 << (k - 2);
      kmask = (1 << k) - 1;
      if (restart) clear_trellis();
      rx = int'(rx_bits) & ((1 << n) - 1);
      foreach (metric_nx[s]) begin
         metric_nx[s]    = 0;
         reachable_nx[s] = 1'b0;
      end
      for (int s = 0; s < ns; s++) begin
         for (int c = 0; c < 2; c++) begin
            p = (c == 0) ? (s >> 1) : ((s >> 1) | top);
            if (!reachable[p]) continue;
            regv     = ((p << 1) | (s & 1)) & kmask;
            exp_bits = 0;
            for (int i = 0; i < n; i++) begin
               taps = ((int'(gen_reg[i]) << 1) | 1) & kmask;
               if (^(taps & regv)) exp_bits |= (1 << i);
            end
            cand = metric[p] + $countones(exp_bits ^ rx);
            if (cand > METRIC_TOP) cand = METRIC_TOP;
            // predecessor s>>1 is tried first, so it keeps ties
            if (!reachable_nx[s] || cand < metric_nx[s]) begin
               metric_nx[s]    = cand;
               reachable_nx[s] = 1'b1;
            end
         end
      end
      any  = 1'b0;
      minm = 0;
      best = 0;
      for (int s = 0; s < ns; s++) begin
         if (reachable_nx[s] && (!any || metric_nx[s] < minm)) begin
            minm = metric_nx[s];
            best = s;
            any  = 1'b1;
         end
      end
      for (int s = 0; s < ns; s++)
         if (reachable_nx[s]) metric_nx[s] -= minm;
      metric    = metric_nx;
      reachable = reachable_nx;
      d.decoded_bit = best[0];
      d.best_state  = STATE_OUT_W'(best);
      return d;
   endfunction

   always @(posedge clock) begin : monitor
      decision_type got, want;
      if (reset) begin
         k_reg = KCFG_W'(K_RESET);
         n_reg = NCFG_W'(N_RESET);
         foreach (gen_reg[i]) gen_reg[i] = GEN_W'(GEN_RESET);
         clear_trellis();
         expected_decisions.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_decoded_bit, rsp_best_state};
            if (expected_decisions.size() == 0) begin
               report_mismatch($sformatf("result with no pending request, state %0d",
                                         rsp_best_state));
            end else begin
               want = expected_decisions.pop_front();
               if (got.best_state !== want.best_state)
                  report_mismatch($sformatf("best_state %0d, expected %0d",
                                            got.best_state, want.best_state));
               if (got.decoded_bit !== want.decoded_bit)
                  report_mismatch($sformatf("decoded_bit %0b, expected %0b",
                                            got.decoded_bit, want.decoded_bit));
            end
         end
         if (csr_we) begin
            case (csr_index)
               CSR_CONSTRAINT: k_reg = csr_wdata[KCFG_W-1:0];
               CSR_NUM_OUT:    n_reg = csr_wdata[NCFG_W-1:0];
               default:        gen_reg[int'(csr_index) - int'(CSR_GEN0)] = csr_wdata;
            endcase
         end
         if (req_valid && !req_stall)
            expected_decisions = {expected_decisions,
                                  acs_decide(req_received_bits, req_first)};
      end
      outstanding = expected_decisions.size();
   end

endmodule

### tb/tb.sv
// Testbench top for the hard-decision Viterbi core: stimulus, settings and verdict.
module tb;
   import vhdd_pkg::*;

   localparam int MAX_K        = 12;
   localparam int IDLE_LIMIT   = 10000;  // covers a K=12 request plus stalls
   localparam int DRAIN_CYCLES = 2100;   // one full K=12 pass for stray results

   bit                       clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic [RX_W-1:0]          req_received_bits;
   logic                     req_first;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic                     rsp_decoded_bit;
   logic [STATE_OUT_W-1:0]   rsp_best_state;
   logic                     csr_we;
   logic [CSR_ADDR_W-1:0]    csr_index;
   logic [CSR_DATA_W-1:0]    csr_wdata;

   int mismatches;
   int outstanding;
   int idle_cycles;

   // quiet phases run with no request gaps and no result stalls
   bit quiet;

   // raw register values last written; the encoder below works from them
   logic [KCFG_W-1:0] cfg_k;
   logic [NCFG_W-1:0] cfg_n;
   logic [GEN_W-1:0]  cfg_gen [NUM_GEN];
   int                enc_state;

   viterbi_hard_decision_decoder_core u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_received_bits (req_received_bits),
      .req_first         (req_first),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_decoded_bit   (rsp_decoded_bit),
      .rsp_best_state    (rsp_best_state),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   vhdd_decision_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_received_bits (req_received_bits),
      .req_first         (req_first),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_decoded_bit   (rsp_decoded_bit),
      .rsp_best_state    (rsp_best_state),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .mismatches        (mismatches),
      .outstanding       (outstanding)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Gap lengths: mostly none, often a few cycles, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 4);
      return $urandom_range(8, 40);
   endfunction

   // Result-side back pressure, changed at the falling edge like every input.
   initial begin : rsp_back_pressure
      int hold;
      rsp_stall = 1'b0;
      hold      = 0;
      forever begin
         @(negedge clock);
         if (hold > 0) hold--;
         else if (!quiet) hold = pick_gap();
         rsp_stall <= (hold > 0) && !quiet;
      end
   end

   // Watchdog: counts cycles in which neither channel moves a request or result.
   initial begin : watchdog
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // Sends one request; entered and left at a falling edge. Valid stays high
   // on return so back-to-back requests need no extra assignment.
   task automatic send_symbol(logic [RX_W-1:0] rx, logic first_flag);
      int gap;
      gap = quiet ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_received_bits <= rx;
      req_first         <= first_flag;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // Either a symbol from a real convolutional encoder (one random data bit,
   // occasionally one flipped coded bit, junk in the unused bits) or noise.
   task automatic next_symbol(logic first_flag, bit encoded);
      int              k, n, kmask, regv, i;
      logic [RX_W-1:0] rx;
      k = int'(cfg_k);
      if (k < 2) k = 2;
      if (k > MAX_K) k = MAX_K;
      n = int'(cfg_n);
      if (n < 1) n = 1;
      if (n > NUM_GEN) n = NUM_GEN;
      kmask = (1 << k) - 1;
      if (first_flag) enc_state = 0;
      if (encoded) begin
         regv = ((enc_state << 1) | int'($urandom_range(0, 1))) & kmask;
         for (i = 0; i < RX_W; i++) begin
            if (i < n) rx[i] = ^((((int'(cfg_gen[i]) << 1) | 1) & kmask) & regv);
            else rx[i] = 1'($urandom_range(0, 1));
         end
         if ($urandom_range(0, 7) == 0) begin
            i     = $urandom_range(0, n - 1);
            rx[i] = ~rx[i];
         end
         enc_state = regv & ((1 << (k - 1)) - 1);
      end else begin
         rx = RX_W'($urandom);
      end
      send_symbol(rx, first_flag);
   endtask

   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
   endtask

   // Holds requests back until every result is in, then writes all eight
   // registers. Spare bits above K and N carry junk the core must drop.
   task automatic apply_settings(logic [KCFG_W-1:0] k, logic [NCFG_W-1:0] n);
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      cfg_k = k;
      cfg_n = n;
      write_reg(CSR_CONSTRAINT, {(CSR_DATA_W - KCFG_W)'($urandom), k});
      write_reg(CSR_NUM_OUT, {(CSR_DATA_W - NCFG_W)'($urandom), n});
      for (int i = 0; i < NUM_GEN; i++)
         write_reg(csr_index_type'(int'(CSR_GEN0) + i), cfg_gen[i]);
      csr_we <= 1'b0;
   endtask

   initial begin : stimulus
      int k_raw, n_raw, count;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_received_bits = '0;
      req_first         = 1'b0;
      csr_we            = 1'b0;
      csr_index         = '0;
      csr_wdata         = '0;
      quiet             = 1'b0;
      enc_state         = 0;
      cfg_k             = KCFG_W'(K_RESET);
      cfg_n             = NCFG_W'(N_RESET);
      foreach (cfg_gen[i]) cfg_gen[i] = GEN_W'(GEN_RESET);
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: reset settings (K=7, two outputs, generators 35).
      send_symbol(6'd0, 1'b1);
      send_symbol(6'd3, 1'b0);
      send_symbol(6'd63, 1'b0);   // bits above the output count set
      send_symbol(6'd60, 1'b0);   // only ignored bits set
      send_symbol(6'd1, 1'b0);
      send_symbol(6'd2, 1'b1);    // restart mid-stream
      send_symbol(6'd63, 1'b1);   // back-to-back restarts
      send_symbol(6'd0, 1'b0);

      // K and N below range saturate to 2 and 1; generator extremes.
      cfg_gen = '{11'h000, 11'h7FF, 11'h400, 11'h001, 11'h023, 11'h555};
      apply_settings(4'd0, 3'd0);
      send_symbol(6'd62, 1'b0);   // unused bits only, bit 0 clear
      send_symbol(6'd1, 1'b0);
      send_symbol(6'd0, 1'b1);

      // K and N above range saturate to 12 and 6: the largest trellis.
      cfg_gen = '{11'h7FF, 11'h000, 11'h400, 11'h001, 11'h023, 11'h555};
      apply_settings(4'd15, 3'd7);
      send_symbol(6'd63, 1'b1);
      send_symbol(6'd0, 1'b0);
      send_symbol(6'd42, 1'b0);

      // Shrink K without a restart: states above the new trellis are dropped.
      foreach (cfg_gen[i]) cfg_gen[i] = GEN_W'($urandom);
      apply_settings(4'd3, 3'd6);
      send_symbol(6'd21, 1'b0);
      send_symbol(6'd63, 1'b0);
      send_symbol(6'd0, 1'b0);

      // Grow K again without a restart: the new upper states start unreachable.
      apply_settings(4'd5, 3'd3);
      send_symbol(6'd7, 1'b0);
      send_symbol(6'd0, 1'b0);

      cfg_gen = '{default: 11'h7FF};
      apply_settings(4'd1, 3'd6);
      send_symbol(6'd63, 1'b0);
      send_symbol(6'd0, 1'b0);

      apply_settings(4'd13, 3'd2);
      send_symbol(6'd5, 1'b0);

      // Random phases. Every phase boundary drains the core first. Most
      // phases send encoded streams with a few stray noise symbols; every
      // third one is all noise. The largest trellis gets only a few requests.
      for (int p = 0; p < 10; p++) begin
         quiet = (p % 4 == 3);
         if (p == 0) begin
            k_raw = 2;
            n_raw = 1;
         end else if (p == 1) begin
            k_raw = MAX_K;
            n_raw = NUM_GEN;
         end else begin
            k_raw = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 1)
                                                : $urandom_range(2, 8);
            n_raw = $urandom_range(0, 7);
         end
         foreach (cfg_gen[i]) cfg_gen[i] = GEN_W'($urandom);
         apply_settings(KCFG_W'(k_raw), NCFG_W'(n_raw));
         count = (k_raw >= 10) ? 8 : 29;
         for (int j = 0; j < count; j++)
            next_symbol((j == 0) || ($urandom_range(0, 19) == 0),
                        (p % 3 != 2) && ($urandom_range(0, 9) != 0));
      end
      quiet = 1'b0;

      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

### viterbi_hard_decision_decoder_core.f
src/vhdd_pkg.sv
src/viterbi_hard_decision_decoder_core.sv
tb/vhdd_decision_checker.sv
tb/tb.sv
